// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on i_clk, off while reset is asserted
`define DEQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// concurrent assertion on i_clk that also holds during reset
`define DEQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== sv/deq_pkg.sv =====
package deq_pkg;

    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SIZE       = 3'd4,
        OP_EMPTY      = 3'd5,
        OP_FRONT      = 3'd6,
        OP_BACK       = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        FAULT_OK    = 2'd0,
        FAULT_EMPTY = 2'd1,
        FAULT_FULL  = 2'd2
    } t_fault;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

endpackage

// ===== sv/deq_if.sv =====
// command channel
interface deq_cmd_if;
    logic          valid;
    logic          ready;
    deq_pkg::t_op  operation;
    logic [31:0]   push_value;

    modport source (output valid, output operation, output push_value, input ready);
    modport sink   (input valid, input operation, input push_value, output ready);
endinterface

// response channel
interface deq_rsp_if;
    logic            valid;
    logic            ready;
    logic [31:0]     result_value;
    deq_pkg::t_fault fault;
    logic            is_empty;

    modport source (output valid, output result_value, output fault, output is_empty,
                    input ready);
    modport sink   (input valid, input result_value, input fault, input is_empty,
                    output ready);
endinterface

// ===== sv/double_ended_queue.sv =====
// Double-ended queue on a ring of DEPTH entries held in one synchronous memory. Each command
// transaction carries an operation and a value: push front/back store the value and give no
// response unless the ring is full (full fault); pop/peek front/back return an element or an
// empty fault; size returns the element count and empty returns 1 or 0. Every response also
// reports whether the ring is empty after the operation. Size, empty and all faulted
// operations answer straight into the output register; pops and peeks first go through the
// registered read port of the element memory. The response sits in an output register, and
// a new command is taken in the same cycle that a waiting response is taken. The memory
// needs no clearing after reset: only entries holding live elements are ever read.
module double_ended_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    deq_cmd_if.sink    i_cmd,
    deq_rsp_if.source  o_rsp
);
    import deq_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // element ring, registered read port
    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    // control state
    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_front, n_front;
    logic [IDX_W-1:0]  r_back,  n_back;
    logic [CNT_W-1:0]  r_count, n_count;

    // response register
    logic              r_out_valid, n_out_valid;
    logic [31:0]       r_out_value, n_out_value;
    t_fault            r_out_fault, n_out_fault;
    logic              r_out_empty, n_out_empty;

    // memory access strobes
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;

    logic cmd_ready;
    logic cmd_acc;
    logic is_full;
    logic is_empty;
    logic out_free;
    logic [IDX_W-1:0] front_prev, front_next, back_prev, back_next;

    assign is_full   = (r_count == FULL_CNT);
    assign is_empty  = (r_count == '0);
    // output register is empty now or is drained at this edge
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign cmd_ready = (r_state == S_IDLE) && out_free;
    assign cmd_acc   = i_cmd.valid && cmd_ready;

    // pointer neighbors with wrap at the ring end
    assign front_prev = (r_front == '0) ? LAST_IDX : r_front - 1'b1;
    assign front_next = (r_front == LAST_IDX) ? '0 : r_front + 1'b1;
    assign back_prev  = (r_back == '0) ? LAST_IDX : r_back - 1'b1;
    assign back_next  = (r_back == LAST_IDX) ? '0 : r_back + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_back      = r_back;
        n_count     = r_count;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_value = r_out_value;
        n_out_fault = r_out_fault;
        n_out_empty = r_out_empty;
        wr_en       = 1'b0;
        wr_addr     = r_back;
        wr_data     = DATA_WIDTH'(i_cmd.push_value);
        rd_en       = 1'b0;
        rd_addr     = r_front;

        case (r_state)
            S_IDLE: begin
                if (cmd_acc) begin
                    case (i_cmd.operation)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            if (is_full) begin
                                // dropped push, answered at once
                                n_out_valid = 1'b1;
                                n_out_value = '0;
                                n_out_fault = FAULT_FULL;
                                n_out_empty = is_empty;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                                if (i_cmd.operation == OP_PUSH_FRONT) begin
                                    wr_addr = front_prev;
                                    n_front = front_prev;
                                end else begin
                                    wr_addr = r_back;
                                    n_back  = back_next;
                                end
                            end
                        end
                        OP_POP_FRONT, OP_FRONT, OP_POP_BACK, OP_BACK: begin
                            if (is_empty) begin
                                n_out_valid = 1'b1;
                                n_out_value = '0;
                                n_out_fault = FAULT_EMPTY;
                                n_out_empty = 1'b1;
                            end else begin
                                rd_en   = 1'b1;
                                n_state = S_READ;
                                if (i_cmd.operation == OP_POP_FRONT ||
                                        i_cmd.operation == OP_FRONT) begin
                                    rd_addr = r_front;
                                end else begin
                                    rd_addr = back_prev;
                                end
                                // pointers and count move now, the data follows
                                if (i_cmd.operation == OP_POP_FRONT) begin
                                    n_front = front_next;
                                    n_count = r_count - 1'b1;
                                end else if (i_cmd.operation == OP_POP_BACK) begin
                                    n_back  = back_prev;
                                    n_count = r_count - 1'b1;
                                end
                            end
                        end
                        OP_SIZE: begin
                            n_out_valid = 1'b1;
                            n_out_value = 32'(r_count);
                            n_out_fault = FAULT_OK;
                            n_out_empty = is_empty;
                        end
                        OP_EMPTY: begin
                            n_out_valid = 1'b1;
                            n_out_value = {31'd0, is_empty};
                            n_out_fault = FAULT_OK;
                            n_out_empty = is_empty;
                        end
                        default: begin
                            n_out_valid = r_out_valid && !o_rsp.ready;
                        end
                    endcase
                end
            end
            S_READ: begin
                // response register was free at the accept edge, so it is empty here
                n_out_valid = 1'b1;
                n_out_value = 32'(r_rdata);
                n_out_fault = FAULT_OK;
                n_out_empty = is_empty;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_back      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_back      <= n_back;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // response payload, no reset
    always_ff @(posedge i_clk) begin
        r_out_value <= n_out_value;
        r_out_fault <= n_out_fault;
        r_out_empty <= n_out_empty;
    end

    // element memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    assign i_cmd.ready        = cmd_ready;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_out_value;
    assign o_rsp.fault        = r_out_fault;
    assign o_rsp.is_empty     = r_out_empty;

endmodule

// ===== sv/deq_checker.sv =====
`include "assert_macros.svh"

module deq_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_cmd_valid,
    input logic            i_cmd_ready,
    input deq_pkg::t_op    i_cmd_op,
    input logic            i_rsp_valid,
    input logic            i_rsp_ready,
    input logic [31:0]     i_rsp_value,
    input deq_pkg::t_fault i_rsp_fault,
    input logic            i_rsp_empty
);
    import deq_pkg::*;

    logic        cmd_acc;
    logic        is_read_op;
    logic        rsp_stall;
    logic        empty_fault;
    logic [34:0] rsp_payload;

    assign cmd_acc     = i_cmd_valid && i_cmd_ready;
    assign is_read_op  = (i_cmd_op == OP_POP_FRONT) || (i_cmd_op == OP_POP_BACK) ||
                         (i_cmd_op == OP_FRONT) || (i_cmd_op == OP_BACK);
    assign rsp_stall   = i_rsp_valid && !i_rsp_ready;
    assign empty_fault = i_rsp_valid && (i_rsp_fault == FAULT_EMPTY);
    assign rsp_payload = {i_rsp_value, i_rsp_fault, i_rsp_empty};

    // no response straight out of reset
    `DEQ_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !i_rsp_valid, "response valid after reset")

    // stalled response keeps its payload
    `DEQ_ASSERT(a_rsp_hold, rsp_stall |=> i_rsp_valid && $stable(rsp_payload), "stalled response changed")

    // size answers on the next cycle with no fault
    `DEQ_ASSERT(a_size_rsp, cmd_acc && i_cmd_op == OP_SIZE |=> i_rsp_valid && i_rsp_fault == FAULT_OK, "size response missing")

    // a pop or peek either answers an empty fault at once or blocks commands for the read
    `DEQ_ASSERT(a_read_gap, cmd_acc && is_read_op |=> !i_cmd_ready || empty_fault, "command taken during element read")

endmodule

bind double_ended_queue deq_checker u_deq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_cmd_op    (i_cmd.operation),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_value (o_rsp.result_value),
    .i_rsp_fault (o_rsp.fault),
    .i_rsp_empty (o_rsp.is_empty)
);
